### hdl/lfr_pkg.sv
// Shared types and constants for the LRU frame replacer.
`timescale 1ns / 1ps

package lfr_pkg;

  // Fixed field widths of the request and result channels.
  localparam int OP_W    = 2;
  localparam int FRAME_W = 6;
  localparam int COUNT_W = 7;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_VICTIM = 2'd0;
  localparam logic [OP_W-1:0] OP_PIN    = 2'd1;
  localparam logic [OP_W-1:0] OP_UNPIN  = 2'd2;

  // Control states of the replacer sequencer.
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } state_t;

endpackage

### hdl/lfr_ram.sv
// Single-port-write, single-port-read synchronous memory with registered read data.
`timescale 1ns / 1ps

module lfr_ram #(
  parameter int WIDTH = 6,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port; the data holds until the next read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### hdl/lru_frame_replacer_unit.sv
// Top level of the LRU frame replacer: sequencer, list ends, count, membership and link memories.
// A result is registered when the execute step after its request transfer completes;
// a stalled output can hold that step off. Requests are taken one at a time: a new one
// waits until the membership and link memory read and write-back for the last is done.
// Reset: synchronous; a clearing pass zeroes all NUM_FRAMES entries of the membership
// memory, and no request is taken until it finishes.
`timescale 1ns / 1ps

module lru_frame_replacer_unit #(
  parameter int NUM_FRAMES = 64
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [lfr_pkg::OP_W-1:0]    operation,
  input  logic [lfr_pkg::FRAME_W-1:0] frame,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        found,
  output logic [lfr_pkg::FRAME_W-1:0] victim_frame,
  output logic [lfr_pkg::COUNT_W-1:0] evictable_count
);

  localparam int AW = $clog2(NUM_FRAMES);
  localparam int WW = AW + lfr_pkg::FRAME_W;

  lfr_pkg::state_t state, state_next;

  // Request and list registers.
  logic [lfr_pkg::OP_W-1:0]    cur_op;
  logic [AW-1:0]               cur_idx;
  logic                        cur_ok;
  logic [AW-1:0]               oldest, oldest_next;
  logic [AW-1:0]               newest, newest_next;
  logic [lfr_pkg::COUNT_W-1:0] listed_count, listed_count_next;
  logic [AW-1:0]               clr_idx;

  // Memory ports.
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          in_wr_en, in_wr_data, in_rd_data;
  logic [AW-1:0] in_wr_addr;
  logic          nx_wr_en;
  logic [AW-1:0] nx_wr_addr, nx_wr_data, nx_rd_data;
  logic          pv_wr_en;
  logic [AW-1:0] pv_wr_addr, pv_wr_data, pv_rd_data;

  // Decoded request and step control.
  logic [WW-1:0] frame_wide;
  logic [AW-1:0] frame_idx;
  logic          frame_ok;
  logic          accept;
  logic          exec_go;
  logic          do_unlink, do_append, is_victim;
  logic [AW-1:0] target;
  logic [WW-1:0] oldest_wide;
  logic          found_next;

  // Frame number mapped onto the memory index range.
  assign frame_wide  = WW'(frame);
  assign frame_idx   = frame_wide[AW-1:0];
  assign frame_ok    = frame_wide < WW'(NUM_FRAMES);
  assign oldest_wide = WW'(oldest);

  assign in_stall = (state != lfr_pkg::ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign exec_go  = (state == lfr_pkg::ST_EXEC) && (!out_valid || !out_stall);

  // Reads are issued on the request transfer; a victim reads the oldest entry.
  assign rd_en   = accept;
  assign rd_addr = (operation == lfr_pkg::OP_VICTIM) ? oldest : frame_idx;

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      lfr_pkg::ST_CLEAR: begin
        if (clr_idx == AW'(NUM_FRAMES - 1)) begin
          state_next = lfr_pkg::ST_IDLE;
        end
      end
      lfr_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = lfr_pkg::ST_EXEC;
        end
      end
      lfr_pkg::ST_EXEC: begin
        if (exec_go) begin
          state_next = lfr_pkg::ST_IDLE;
        end
      end
      default: state_next = lfr_pkg::ST_CLEAR;
    endcase
  end

  // Unlink and append decisions from the membership read.
  assign is_victim = (cur_op == lfr_pkg::OP_VICTIM);
  assign target    = is_victim ? oldest : cur_idx;
  assign do_unlink = exec_go && ((is_victim && listed_count != '0) ||
                     (cur_op == lfr_pkg::OP_PIN && cur_ok && in_rd_data));
  assign do_append = exec_go && (cur_op == lfr_pkg::OP_UNPIN) && cur_ok && !in_rd_data;
  assign found_next = is_victim && (listed_count != '0);

  // Output logic: clearing writes, memory write-back and list updates.
  always_comb begin
    in_wr_en          = 1'b0;
    in_wr_addr        = target;
    in_wr_data        = 1'b0;
    nx_wr_en          = 1'b0;
    nx_wr_addr        = pv_rd_data;
    nx_wr_data        = nx_rd_data;
    pv_wr_en          = 1'b0;
    pv_wr_addr        = nx_rd_data;
    pv_wr_data        = pv_rd_data;
    oldest_next       = oldest;
    newest_next       = newest;
    listed_count_next = listed_count;
    case (state)
      lfr_pkg::ST_CLEAR: begin
        in_wr_en   = 1'b1;
        in_wr_addr = clr_idx;
      end
      lfr_pkg::ST_EXEC: begin
        if (do_unlink) begin
          // Splice the target out between its older and newer neighbors.
          in_wr_en = 1'b1;
          if (target == oldest) begin
            oldest_next = nx_rd_data;
          end else begin
            nx_wr_en = 1'b1;
          end
          if (target == newest) begin
            newest_next = pv_rd_data;
          end else begin
            pv_wr_en = 1'b1;
          end
          listed_count_next = listed_count - lfr_pkg::COUNT_W'(1);
        end else if (do_append) begin
          // Attach the frame behind the current newest entry.
          in_wr_en   = 1'b1;
          in_wr_addr = cur_idx;
          in_wr_data = 1'b1;
          if (listed_count == '0) begin
            oldest_next = cur_idx;
          end else begin
            nx_wr_en   = 1'b1;
            nx_wr_addr = newest;
            nx_wr_data = cur_idx;
            pv_wr_en   = 1'b1;
            pv_wr_addr = cur_idx;
            pv_wr_data = newest;
          end
          newest_next       = cur_idx;
          listed_count_next = listed_count + lfr_pkg::COUNT_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= lfr_pkg::ST_CLEAR;
      clr_idx      <= '0;
      oldest       <= '0;
      newest       <= '0;
      listed_count <= '0;
      out_valid    <= 1'b0;
    end else begin
      state        <= state_next;
      oldest       <= oldest_next;
      newest       <= newest_next;
      listed_count <= listed_count_next;
      if (state == lfr_pkg::ST_CLEAR) begin
        clr_idx <= clr_idx + AW'(1);
      end
      if (exec_go) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Request capture and result register.
  always_ff @(posedge clk) begin
    if (accept) begin
      cur_op  <= operation;
      cur_idx <= frame_idx;
      cur_ok  <= frame_ok;
    end
    if (exec_go) begin
      found           <= found_next;
      victim_frame    <= found_next ? oldest_wide[lfr_pkg::FRAME_W-1:0] : '0;
      evictable_count <= listed_count_next;
    end
  end

  // Membership flags.
  lfr_ram #(.WIDTH(1), .DEPTH(NUM_FRAMES)) u_in_order (
    .clk     (clk),
    .wr_en   (in_wr_en),
    .wr_addr (in_wr_addr),
    .wr_data (in_wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (in_rd_data)
  );

  // Links toward the newer neighbor.
  lfr_ram #(.WIDTH(AW), .DEPTH(NUM_FRAMES)) u_next_link (
    .clk     (clk),
    .wr_en   (nx_wr_en),
    .wr_addr (nx_wr_addr),
    .wr_data (nx_wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (nx_rd_data)
  );

  // Links toward the older neighbor.
  lfr_ram #(.WIDTH(AW), .DEPTH(NUM_FRAMES)) u_prev_link (
    .clk     (clk),
    .wr_en   (pv_wr_en),
    .wr_addr (pv_wr_addr),
    .wr_data (pv_wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (pv_rd_data)
  );

endmodule
